// ----- rtl/core/eanbc_pkg.sv -----
// Package with the types, code tables and microcode program of the EAN bar-module encoder.
package eanbc_pkg;

    localparam int unsigned MAX_DIGITS    = 13;
    localparam int unsigned PC_W          = 6;
    localparam int unsigned QUIET_MODULES = 32;
    localparam logic [7:0]  CHAR_ZERO     = 8'h30;
    localparam logic [3:0]  DIGIT_MAX     = 4'd9;
    localparam logic [3:0]  DIGIT_BASE    = 4'd10;

    // Program entry points used by jumps.
    localparam logic [PC_W-1:0] STEP_EAN8   = 6'd28;
    localparam logic [PC_W-1:0] STEP_CHECK  = 6'd36;
    localparam logic [PC_W-1:0] STEP_REJECT = 6'd40;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_START,
        OP_ACC,
        OP_CHK,
        OP_QUIET,
        OP_GUARD3,
        OP_GUARD5,
        OP_LEFT,
        OP_RIGHT,
        OP_CHECKSEG,
        OP_END,
        OP_REJECT
    } t_op;

    typedef enum logic [2:0] {
        JC_NONE,
        JC_BAD,
        JC_EAN8,
        JC_ALWAYS,
        JC_DONE
    } t_jc;

    typedef struct packed {
        t_op             op;
        logic [3:0]      idx;
        logic [2:0]      par;
        t_jc             jc;
        logic [PC_W-1:0] target;
    } t_ucw;

    typedef struct packed {
        logic       fire;
        logic       emit;
        logic       clear;
        t_op        op;
        logic [3:0] idx;
        logic [2:0] par;
    } t_dp_ctrl;

    typedef struct packed {
        logic invalid;
        logic ean8;
    } t_dp_stat;

    typedef struct packed {
        logic [31:0] modules;
        logic [5:0]  module_count;
        logic [3:0]  check_digit;
        logic        accepted;
        logic        end_of_symbol;
    } t_seg;

    // Seven-module digit patterns, first module in bit 6.
    function automatic logic [6:0] pat_odd(input logic [3:0] d);
        logic [6:0] p;
        case (d)
            4'd0: p = 7'h0D;
            4'd1: p = 7'h19;
            4'd2: p = 7'h13;
            4'd3: p = 7'h3D;
            4'd4: p = 7'h23;
            4'd5: p = 7'h31;
            4'd6: p = 7'h2F;
            4'd7: p = 7'h3B;
            4'd8: p = 7'h37;
            4'd9: p = 7'h0B;
            default: p = 7'h0D;
        endcase
        return p;
    endfunction

    function automatic logic [6:0] pat_even(input logic [3:0] d);
        logic [6:0] p;
        case (d)
            4'd0: p = 7'h27;
            4'd1: p = 7'h33;
            4'd2: p = 7'h1B;
            4'd3: p = 7'h21;
            4'd4: p = 7'h1D;
            4'd5: p = 7'h39;
            4'd6: p = 7'h05;
            4'd7: p = 7'h11;
            4'd8: p = 7'h09;
            4'd9: p = 7'h17;
            default: p = 7'h27;
        endcase
        return p;
    endfunction

    function automatic logic [6:0] pat_right(input logic [3:0] d);
        logic [6:0] p;
        case (d)
            4'd0: p = 7'h72;
            4'd1: p = 7'h66;
            4'd2: p = 7'h6C;
            4'd3: p = 7'h42;
            4'd4: p = 7'h5C;
            4'd5: p = 7'h4E;
            4'd6: p = 7'h50;
            4'd7: p = 7'h44;
            4'd8: p = 7'h48;
            4'd9: p = 7'h74;
            default: p = 7'h72;
        endcase
        return p;
    endfunction

    // Parity of the six left digits of EAN-13, first in bit 5, 1 means even.
    function automatic logic [5:0] first_parity(input logic [3:0] d);
        logic [5:0] p;
        case (d)
            4'd0: p = 6'h00;
            4'd1: p = 6'h0B;
            4'd2: p = 6'h0D;
            4'd3: p = 6'h0E;
            4'd4: p = 6'h13;
            4'd5: p = 6'h19;
            4'd6: p = 6'h1C;
            4'd7: p = 6'h15;
            4'd8: p = 6'h16;
            4'd9: p = 6'h1A;
            default: p = 6'h00;
        endcase
        return p;
    endfunction

    function automatic logic op_emits(input t_op op);
        logic e;
        case (op) inside
            OP_NOP, OP_START, OP_ACC, OP_CHK: e = 1'b0;
            default: e = 1'b1;
        endcase
        return e;
    endfunction

    function automatic t_ucw mk(input t_op op, input logic [3:0] idx, input logic [2:0] par,
                                input t_jc jc, input logic [PC_W-1:0] target);
        t_ucw w;
        w.op     = op;
        w.idx    = idx;
        w.par    = par;
        w.jc     = jc;
        w.target = target;
        return w;
    endfunction

    // The control program: checksum pass, then one symbol segment per step; an invalid code jumps to the reject step.
    function automatic t_ucw ucode(input logic [PC_W-1:0] pc);
        t_ucw w;
        case (pc) inside
            6'd0:          w = mk(OP_START, 4'd0, 3'd0, JC_BAD, STEP_REJECT);
            [6'd1:6'd12]:  w = mk(OP_ACC, 4'(pc - 6'd1), 3'd0, JC_NONE, 6'd0);
            6'd13:         w = mk(OP_CHK, 4'd12, 3'd0, JC_NONE, 6'd0);
            6'd14:         w = mk(OP_QUIET, 4'd0, 3'd0, JC_NONE, 6'd0);
            6'd15:         w = mk(OP_GUARD3, 4'd0, 3'd0, JC_EAN8, STEP_EAN8);
            [6'd16:6'd21]: w = mk(OP_LEFT, 4'(pc - 6'd15), 3'(pc - 6'd16), JC_NONE, 6'd0);
            6'd22:         w = mk(OP_GUARD5, 4'd0, 3'd0, JC_NONE, 6'd0);
            [6'd23:6'd26]: w = mk(OP_RIGHT, 4'(pc - 6'd16), 3'd0, JC_NONE, 6'd0);
            6'd27:         w = mk(OP_RIGHT, 4'd11, 3'd0, JC_ALWAYS, STEP_CHECK);
            [6'd28:6'd31]: w = mk(OP_LEFT, 4'(pc - 6'd28), 3'd0, JC_NONE, 6'd0);
            6'd32:         w = mk(OP_GUARD5, 4'd0, 3'd0, JC_NONE, 6'd0);
            [6'd33:6'd35]: w = mk(OP_RIGHT, 4'(pc - 6'd29), 3'd0, JC_NONE, 6'd0);
            6'd36:         w = mk(OP_CHECKSEG, 4'd0, 3'd0, JC_NONE, 6'd0);
            6'd37:         w = mk(OP_GUARD3, 4'd0, 3'd0, JC_NONE, 6'd0);
            6'd38:         w = mk(OP_QUIET, 4'd0, 3'd0, JC_NONE, 6'd0);
            6'd39:         w = mk(OP_END, 4'd0, 3'd0, JC_DONE, 6'd0);
            6'd40:         w = mk(OP_REJECT, 4'd0, 3'd0, JC_DONE, 6'd0);
            default:       w = mk(OP_NOP, 4'd0, 3'd0, JC_DONE, 6'd0);
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/ean_barcode_module_encoder.sv -----
// Top level of the EAN bar-module encoder: input port, sequencer, datapath and output register.
//
//  channel   direction  tdata (low bit up)                          tuser     tlast
//  s_axis    in         char_code[7:0]                              -         last
//  m_axis    out        modules[31:0] module_count[37:32]           accepted  end_of_symbol
//                       check_digit[41:38] zero[47:42]
//
// Characters are taken one per cycle. The word marked last starts a microcode program of
// one step per cycle: 14 checksum steps, then one step per sent word; a rejected code runs
// only its start step and the reject step. The single step counter runs the program.
// The input is not ready while the program runs. A stalled output freezes the step counter
// on a step that sends a word. Reset is synchronous; the digit store is not cleared.
module ean_barcode_module_encoder #(
    parameter int unsigned QUIET_MODULES = eanbc_pkg::QUIET_MODULES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // modules, module_count, check_digit, zero fill
    output logic        m_axis_tuser,   // accepted
    output logic        m_axis_tlast
);

    eanbc_pkg::t_dp_ctrl ctrl;
    eanbc_pkg::t_dp_stat stat;
    eanbc_pkg::t_seg     seg;
    eanbc_pkg::t_seg     r_seg;
    logic                r_valid;
    logic                busy;
    logic                load;
    logic                out_free;

    assign s_axis_tready = !busy;
    assign load          = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_valid || m_axis_tready;

    eanbc_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (load && s_axis_tlast),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_busy     (busy)
    );

    eanbc_datapath #(
        .QUIET_MODULES (QUIET_MODULES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_char  (s_axis_tdata),
        .i_ctrl  (ctrl),
        .o_stat  (stat),
        .o_seg   (seg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_seg <= seg;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {6'd0, r_seg.check_digit, r_seg.module_count, r_seg.modules};
    assign m_axis_tuser  = r_seg.accepted;
    assign m_axis_tlast  = r_seg.end_of_symbol;

`ifndef SYNTHESIS
    // The program must start on the code's final character and close the input.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still ready after the final character");

    // A reject word is always the only and final word of its code.
    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[37:32] == 6'd0))
        else $error("reject word without end marking");

    // Every segment inside a symbol has a legal module count.
    a_seg_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            (m_axis_tdata[37:32] == 6'd3) || (m_axis_tdata[37:32] == 6'd5) ||
            (m_axis_tdata[37:32] == 6'd7) ||
            (m_axis_tdata[37:32] == 6'(QUIET_MODULES)))
        else $error("segment with an illegal module count");
`endif

endmodule

// ----- rtl/core/eanbc_datapath.sv -----
// Datapath of the EAN encoder: digit store, checksum unit and segment builder.
module eanbc_datapath #(
    parameter int unsigned QUIET_MODULES = eanbc_pkg::QUIET_MODULES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [7:0]          i_char,
    input  eanbc_pkg::t_dp_ctrl i_ctrl,
    output eanbc_pkg::t_dp_stat o_stat,
    output eanbc_pkg::t_seg     o_seg
);

    logic [3:0] r_store [eanbc_pkg::MAX_DIGITS];
    logic [3:0] r_count;
    logic       r_bad;
    logic       r_term;
    logic [3:0] r_sum;
    logic [3:0] r_check;

    logic [7:0] char_dig;
    logic       char_bad;
    logic [3:0] char_val;
    logic       take_char;
    logic       len_ok;
    logic       len13;
    logic       ean8;
    logic [3:0] rd;
    logic       w3;
    logic [4:0] term;
    logic [5:0] acc;
    logic [3:0] n_sum;
    logic [3:0] n_check;
    logic [5:0] par_bits;
    logic       even;

    assign char_dig  = i_char - eanbc_pkg::CHAR_ZERO;
    assign char_bad  = char_dig > 8'(eanbc_pkg::DIGIT_MAX);
    assign char_val  = char_bad ? 4'd0 : char_dig[3:0];
    assign take_char = i_load && !r_term && (r_count < 4'(eanbc_pkg::MAX_DIGITS));

    assign len13  = r_count == 4'd13;
    assign ean8   = r_count < 4'd12;
    assign len_ok = len13 || (r_count == 4'd12) || (r_count == 4'd8) || (r_count == 4'd7);
    assign o_stat.invalid = r_bad || !len_ok;
    assign o_stat.ean8    = ean8;

    assign rd = r_store[i_ctrl.idx];

    // EAN-13 weights odd positions by three, EAN-8 the even ones; EAN-8 sums only seven digits.
    always_comb begin
        w3   = i_ctrl.idx[0] ^ ean8;
        term = w3 ? (5'({rd, 1'b0}) + 5'(rd)) : 5'(rd);
        if (ean8 && (i_ctrl.idx >= 4'd7)) begin
            term = 5'd0;
        end
        acc = 6'(r_sum) + 6'(term);
        if (acc >= 6'd30) begin
            n_sum = 4'(acc - 6'd30);
        end else if (acc >= 6'd20) begin
            n_sum = 4'(acc - 6'd20);
        end else if (acc >= 6'd10) begin
            n_sum = 4'(acc - 6'd10);
        end else begin
            n_sum = acc[3:0];
        end
    end

    always_comb begin
        if (len13) begin
            n_check = r_store[12];
        end else if (r_sum == 4'd0) begin
            n_check = 4'd0;
        end else begin
            n_check = eanbc_pkg::DIGIT_BASE - r_sum;
        end
    end

    assign par_bits = eanbc_pkg::first_parity(r_store[0]);
    assign even     = !ean8 && par_bits[3'd5 - i_ctrl.par];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 4'd0;
            r_bad   <= 1'b0;
            r_term  <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_count <= 4'd0;
            r_bad   <= 1'b0;
            r_term  <= 1'b0;
        end else if (take_char) begin
            if (i_char == 8'd0) begin
                r_term <= 1'b1;
            end else begin
                r_count <= r_count + 4'd1;
                r_bad   <= r_bad | char_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_char && (i_char != 8'd0)) begin
            r_store[r_count] <= char_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= 4'd0;
        end else if (i_ctrl.fire) begin
            if (i_ctrl.op == eanbc_pkg::OP_START) begin
                r_sum <= 4'd0;
            end else if (i_ctrl.op == eanbc_pkg::OP_ACC) begin
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire && (i_ctrl.op == eanbc_pkg::OP_CHK)) begin
            r_check <= n_check;
        end
    end

    always_comb begin
        o_seg.modules       = 32'd0;
        o_seg.module_count  = 6'd0;
        o_seg.check_digit   = r_check;
        o_seg.accepted      = 1'b1;
        o_seg.end_of_symbol = 1'b0;
        unique case (i_ctrl.op)
            eanbc_pkg::OP_QUIET: begin
                o_seg.module_count = 6'(QUIET_MODULES);
            end
            eanbc_pkg::OP_GUARD3: begin
                o_seg.modules      = 32'h5;
                o_seg.module_count = 6'd3;
            end
            eanbc_pkg::OP_GUARD5: begin
                o_seg.modules      = 32'hA;
                o_seg.module_count = 6'd5;
            end
            eanbc_pkg::OP_LEFT: begin
                o_seg.modules      = 32'(even ? eanbc_pkg::pat_even(rd) : eanbc_pkg::pat_odd(rd));
                o_seg.module_count = 6'd7;
            end
            eanbc_pkg::OP_RIGHT: begin
                o_seg.modules      = 32'(eanbc_pkg::pat_right(rd));
                o_seg.module_count = 6'd7;
            end
            eanbc_pkg::OP_CHECKSEG: begin
                o_seg.modules      = 32'(eanbc_pkg::pat_right(r_check));
                o_seg.module_count = 6'd7;
            end
            eanbc_pkg::OP_END: begin
                o_seg.end_of_symbol = 1'b1;
            end
            eanbc_pkg::OP_REJECT: begin
                o_seg.check_digit   = 4'd0;
                o_seg.accepted      = 1'b0;
                o_seg.end_of_symbol = 1'b1;
            end
            default: begin
                o_seg.module_count = 6'd0;
            end
        endcase
    end

endmodule

// ----- rtl/core/eanbc_sequencer.sv -----
// Microcode sequencer of the EAN encoder: step counter, program table and jump logic.
module eanbc_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_out_free,
    input  eanbc_pkg::t_dp_stat i_stat,
    output eanbc_pkg::t_dp_ctrl o_ctrl,
    output logic                o_busy
);

    logic                       r_run;
    logic [eanbc_pkg::PC_W-1:0] r_pc;
    logic [eanbc_pkg::PC_W-1:0] n_pc;
    eanbc_pkg::t_ucw            ucw;
    logic                       emits;
    logic                       fire;
    logic                       take;

    assign ucw   = eanbc_pkg::ucode(r_pc);
    assign emits = eanbc_pkg::op_emits(ucw.op);
    // A step that sends a word waits until the output register can take it.
    assign fire  = r_run && (!emits || i_out_free);

    always_comb begin
        unique case (ucw.jc)
            eanbc_pkg::JC_NONE:   take = 1'b0;
            eanbc_pkg::JC_BAD:    take = i_stat.invalid;
            eanbc_pkg::JC_EAN8:   take = i_stat.ean8;
            eanbc_pkg::JC_ALWAYS: take = 1'b1;
            eanbc_pkg::JC_DONE:   take = 1'b0;
            default:              take = 1'b0;
        endcase
        n_pc = take ? ucw.target : r_pc + 6'd1;
    end

    always_comb begin
        o_ctrl.fire  = fire;
        o_ctrl.emit  = fire && emits;
        o_ctrl.clear = fire && (ucw.jc == eanbc_pkg::JC_DONE);
        o_ctrl.op    = ucw.op;
        o_ctrl.idx   = ucw.idx;
        o_ctrl.par   = ucw.par;
    end

    assign o_busy = r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pc  <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_pc  <= '0;
        end else if (fire) begin
            if (ucw.jc == eanbc_pkg::JC_DONE) begin
                r_run <= 1'b0;
            end
            r_pc <= n_pc;
        end
    end

endmodule

// ----- tb/ean_barcode_module_encoder_tb.sv -----
// Self-checking testbench of the EAN bar-module encoder: directed codes, then random codes.
module ean_barcode_module_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_WAIT  = 48;
    localparam int PHASE_ITEMS  = 60;
    localparam int NUM_PHASES   = 4;
    localparam int SEND_IDLE [NUM_PHASES] = '{0, 51, 0, 20};
    localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 51, 20};

    // Module patterns of the three digit sets, first module in bit 6.
    localparam logic [6:0] SET_ODD  [10] = '{7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23,
                                             7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B};
    localparam logic [6:0] SET_EVEN [10] = '{7'h27, 7'h33, 7'h1B, 7'h21, 7'h1D,
                                             7'h39, 7'h05, 7'h11, 7'h09, 7'h17};
    localparam logic [6:0] SET_RIGHT[10] = '{7'h72, 7'h66, 7'h6C, 7'h42, 7'h5C,
                                             7'h4E, 7'h50, 7'h44, 7'h48, 7'h74};
    // Parity of the six left digits of EAN-13, chosen by the leading digit; 1 means even.
    localparam logic [5:0] LEAD_PARITY[10] = '{6'h00, 6'h0B, 6'h0D, 6'h0E, 6'h13,
                                               6'h19, 6'h1C, 6'h15, 6'h16, 6'h1A};
    localparam logic [31:0] GUARD_EDGE   = 32'h5;
    localparam logic [31:0] GUARD_CENTRE = 32'hA;

    typedef enum logic [2:0] {
        KIND_EAN13,
        KIND_EAN12,
        KIND_EAN8,
        KIND_EAN7,
        KIND_BROKEN,
        KIND_NOISE
    } t_code_kind;

    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
        logic       fixed_reject;
    } t_char_row;

    // Directed codes. Rows with fixed_reject set expect the single reject word.
    localparam int NUM_DIRECTED = 21;
    localparam t_char_row DIRECTED[NUM_DIRECTED] = '{
        '{8'hFF, 1'b1, 1'b1},   // non-digit at the top of the byte range, right after reset
        '{8'h00, 1'b1, 1'b1},   // terminator with nothing counted
        '{8'h30, 1'b0, 1'b0},   // seven digits: EAN-8 with computed check digit
        '{8'h31, 1'b0, 1'b0},
        '{8'h32, 1'b0, 1'b0},
        '{8'h33, 1'b0, 1'b0},
        '{8'h34, 1'b0, 1'b0},
        '{8'h35, 1'b0, 1'b0},
        '{8'h36, 1'b1, 1'b0},
        '{8'h39, 1'b0, 1'b0},   // eight digits, the given check digit is replaced
        '{8'h38, 1'b0, 1'b0},
        '{8'h37, 1'b0, 1'b0},
        '{8'h36, 1'b0, 1'b0},
        '{8'h35, 1'b0, 1'b0},
        '{8'h34, 1'b0, 1'b0},
        '{8'h33, 1'b0, 1'b0},
        '{8'h39, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0},   // terminator, then a character that must be ignored
        '{8'hFF, 1'b1, 1'b0},
        '{8'h2F, 1'b1, 1'b1},   // just below the digit range
        '{8'h3A, 1'b1, 1'b1}    // just above the digit range
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // char_code[7:0]
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // modules, module_count, check_digit, zero fill
    logic        m_axis_tuser;          // accepted
    logic        m_axis_tlast;

    // Encoder state as the predictor sees it.
    logic [3:0]  held_digits[eanbc_pkg::MAX_DIGITS] = '{default: 4'd0};
    int unsigned held_len  = 0;
    bit          bad_seen  = 1'b0;
    bit          stop_seen = 1'b0;

    eanbc_pkg::t_seg staged_words[$];
    eanbc_pkg::t_seg expected_words[$];
    int          errors      = 0;
    int          cycles      = 0;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int          hold_req    = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int          phase_items = 0;

    ean_barcode_module_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    function automatic eanbc_pkg::t_seg make_word(input logic [31:0] m, input logic [5:0] cnt,
                                                  input logic [3:0] ck, input logic acc,
                                                  input logic eos);
        eanbc_pkg::t_seg w;
        w.modules       = m;
        w.module_count  = cnt;
        w.check_digit   = ck;
        w.accepted      = acc;
        w.end_of_symbol = eos;
        return w;
    endfunction

    // Takes one character into the code and, on the last one, stages the symbol words.
    task automatic encode_char(input logic [7:0] ch, input logic lst);
        logic [7:0]  v;
        int unsigned sum;
        logic [3:0]  ck;
        logic [5:0]  par;
        int          i;
        if (!stop_seen && held_len < eanbc_pkg::MAX_DIGITS) begin
            if (ch == 8'h00) begin
                stop_seen = 1'b1;
            end else begin
                v = ch - eanbc_pkg::CHAR_ZERO;
                if (v > 8'd9) begin
                    bad_seen = 1'b1;
                    v = 8'd0;
                end
                held_digits[held_len] = v[3:0];
                held_len++;
            end
        end
        if (!lst) return;

        if (bad_seen || !(held_len inside {7, 8, 12, 13})) begin
            staged_words.push_back(make_word(32'd0, 6'd0, 4'd0, 1'b0, 1'b1));
        end else begin
            sum = 0;
            if (held_len == 13) begin
                ck = held_digits[12];
            end else begin
                if (held_len == 12) begin
                    for (i = 0; i < 12; i++)
                        sum += int'(held_digits[i]) * ((i % 2) ? 3 : 1);
                end else begin
                    for (i = 0; i < 7; i++)
                        sum += int'(held_digits[i]) * ((i % 2) ? 1 : 3);
                end
                ck = 4'((10 - sum % 10) % 10);
            end
            staged_words.push_back(make_word(32'd0, 6'(eanbc_pkg::QUIET_MODULES), ck, 1'b1,
                                             1'b0));
            staged_words.push_back(make_word(GUARD_EDGE, 6'd3, ck, 1'b1, 1'b0));
            if (held_len >= 12) begin
                par = LEAD_PARITY[held_digits[0]];
                for (i = 0; i < 6; i++)
                    staged_words.push_back(make_word(
                        32'(par[5-i] ? SET_EVEN[held_digits[i+1]] : SET_ODD[held_digits[i+1]]),
                        6'd7, ck, 1'b1, 1'b0));
                staged_words.push_back(make_word(GUARD_CENTRE, 6'd5, ck, 1'b1, 1'b0));
                for (i = 7; i < 12; i++)
                    staged_words.push_back(make_word(32'(SET_RIGHT[held_digits[i]]), 6'd7, ck,
                                                     1'b1, 1'b0));
            end else begin
                for (i = 0; i < 4; i++)
                    staged_words.push_back(make_word(32'(SET_ODD[held_digits[i]]), 6'd7, ck,
                                                     1'b1, 1'b0));
                staged_words.push_back(make_word(GUARD_CENTRE, 6'd5, ck, 1'b1, 1'b0));
                for (i = 4; i < 7; i++)
                    staged_words.push_back(make_word(32'(SET_RIGHT[held_digits[i]]), 6'd7, ck,
                                                     1'b1, 1'b0));
            end
            staged_words.push_back(make_word(32'(SET_RIGHT[ck]), 6'd7, ck, 1'b1, 1'b0));
            staged_words.push_back(make_word(GUARD_EDGE, 6'd3, ck, 1'b1, 1'b0));
            staged_words.push_back(make_word(32'd0, 6'(eanbc_pkg::QUIET_MODULES), ck, 1'b1,
                                             1'b0));
            staged_words.push_back(make_word(32'd0, 6'd0, ck, 1'b1, 1'b1));
        end
        held_len  = 0;
        bad_seen  = 1'b0;
        stop_seen = 1'b0;
    endtask

    // Offers one character word and predicts once it has been taken.
    task automatic send_char(input logic [7:0] ch, input logic lst, input logic fixed_reject);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        encode_char(ch, lst);
        if (fixed_reject) begin
            staged_words.delete();
            expected_words.push_back(make_word(32'd0, 6'd0, 4'd0, 1'b0, 1'b1));
        end else begin
            while (staged_words.size() != 0)
                expected_words.push_back(staged_words.pop_front());
        end
    endtask

    function automatic t_code_kind pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 30) return KIND_EAN13;
        if (r < 50) return KIND_EAN12;
        if (r < 65) return KIND_EAN8;
        if (r < 75) return KIND_EAN7;
        if (r < 87) return KIND_BROKEN;
        return KIND_NOISE;
    endfunction

    // Builds one code of the given kind and sends it, the last word marked.
    task automatic send_code(input t_code_kind kind);
        logic [7:0] chars[$];
        logic [7:0] b;
        int         len;
        int         i;
        int         r;
        case (kind)
            KIND_EAN13: len = 13;
            KIND_EAN12: len = 12;
            KIND_EAN8:  len = 8;
            KIND_EAN7:  len = 7;
            KIND_BROKEN: begin
                r = $urandom_range(3);
                len = (r == 0) ? 7 : (r == 1) ? 8 : (r == 2) ? 12 : 13;
            end
            default:    len = $urandom_range(1, 16);
        endcase

        for (i = 0; i < len; i++) begin
            if (kind == KIND_NOISE) begin
                r = $urandom_range(9);
                if (r < 6)
                    b = 8'(eanbc_pkg::CHAR_ZERO + $urandom_range(9));
                else if (r < 9)
                    b = 8'($urandom_range(255));
                else
                    b = 8'h00;
            end else begin
                b = 8'(eanbc_pkg::CHAR_ZERO + $urandom_range(9));
            end
            chars.push_back(b);
        end
        phase_items += len;

        if (kind == KIND_BROKEN) begin
            do b = 8'($urandom_range(1, 255)); while (b inside {[8'h30:8'h39]});
            chars[$urandom_range(len - 1)] = b;
        end

        // Codes other than noise sometimes carry a terminator or extra characters past the 13th.
        if (kind != KIND_NOISE) begin
            r = $urandom_range(9);
            if (r < 2) begin
                chars.push_back(8'h00);
                repeat ($urandom_range(2)) chars.push_back(8'($urandom_range(255)));
            end else if (r == 2 && len == 13) begin
                repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(255)));
            end
        end

        for (i = 0; i < chars.size(); i++)
            send_char(chars[i], i == chars.size() - 1, 1'b0);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    // The receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        eanbc_pkg::t_seg want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: tdata %h tuser %b tlast %b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (m_axis_tdata[31:0] !== want.modules) begin
                    $error("modules: expected %h, got %h", want.modules, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[37:32] !== want.module_count) begin
                    $error("module_count: expected %0d, got %0d",
                           want.module_count, m_axis_tdata[37:32]);
                    errors++;
                end
                if (m_axis_tdata[41:38] !== want.check_digit) begin
                    $error("check_digit: expected %0d, got %0d",
                           want.check_digit, m_axis_tdata[41:38]);
                    errors++;
                end
                if (m_axis_tdata[47:42] !== 6'd0) begin
                    $error("zero fill: expected 0, got %h", m_axis_tdata[47:42]);
                    errors++;
                end
                if (m_axis_tuser !== want.accepted) begin
                    $error("accepted: expected %b, got %b", want.accepted, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== want.end_of_symbol) begin
                    $error("end_of_symbol: expected %b, got %b",
                           want.end_of_symbol, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("ean_barcode_module_encoder_tb: errors");
            $finish;
        end
    end

    initial begin
        int row;
        int ph;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < NUM_DIRECTED; row++)
            send_char(DIRECTED[row].ch, DIRECTED[row].lst, DIRECTED[row].fixed_reject);
        drain_results();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            idle_pct    = SEND_IDLE[ph];
            stall_pct   = RECV_STALL[ph];
            phase_items = 0;
            // In the first phase the receiver holds off while codes keep coming.
            if (ph == 0) hold_req++;
            while (phase_items < PHASE_ITEMS) send_code(pick_kind());
            drain_results();
        end

        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("ean_barcode_module_encoder_tb: clean");
        else
            $display("ean_barcode_module_encoder_tb: errors");
        $finish;
    end

endmodule

// ----- ean_barcode_module_encoder.f -----
rtl/core/eanbc_pkg.sv
rtl/core/eanbc_datapath.sv
rtl/core/eanbc_sequencer.sv
rtl/core/ean_barcode_module_encoder.sv
tb/ean_barcode_module_encoder_tb.sv
